### rtl/decimal_number_tile_printer_macros.svh
// Assertion macros shared by the decimal number tile printer RTL.
// Every macro expects a clock named clk and an active-low reset named rst_n.
`ifndef DECIMAL_NUMBER_TILE_PRINTER_MACROS_SVH
`define DECIMAL_NUMBER_TILE_PRINTER_MACROS_SVH

// Property holds on every clock edge out of reset.
`define DNTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define DNTP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DNTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dntp_pkg.sv
// Package for the decimal number tile printer: widths, constants, types.
// No dependencies; used by the interfaces, dntp_conv and the top level.
package dntp_pkg;

  localparam int DIGITS    = 5;
  localparam int ROW_TILES = 32;

  localparam int ADDR_W   = 14;
  localparam int COL_W    = 5;
  localparam int LINE_W   = 5;
  localparam int VALUE_W  = 16;
  localparam int LEN_W    = 3;
  localparam int DIGIT_W  = 4;
  localparam int CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

  localparam logic [ADDR_W-1:0] NTB_RESET = 14'd6144;

  // Register index codes (byte address bit 2 selects the register)
  localparam logic REG_NTB = 1'b0;

  // Reciprocal multipliers for divide by 100 and by 10
  localparam int MUL_DIV100_WIDE   = 167773;  // >>24, exact for 16-bit values
  localparam int MUL_DIV100_NARROW = 41;      // >>12, exact below 1000
  localparam int MUL_DIV10         = 103;     // >>10, exact below 100

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    addr_t              addr;
    len_t               len;
  } conv_in_t;

  typedef struct packed {
    digit_t [DIGITS-1:0] digit;  // digit[0] is the ten-thousands place
    addr_t               addr;
    len_t                len;
  } conv_out_t;

endpackage

### rtl/dntp_ifs.sv
// Valid/ready channel interfaces for the printer's input and result sides.
// Depends on dntp_pkg for field widths.
interface dntp_in_if;
  logic                            valid;
  logic                            ready;
  logic [dntp_pkg::COL_W-1:0]      column;
  logic [dntp_pkg::LINE_W-1:0]     line;
  logic [dntp_pkg::VALUE_W-1:0]    value;
  logic [dntp_pkg::LEN_W-1:0]      length;

  modport source (output valid, column, line, value, length, input ready);
  modport sink   (input valid, column, line, value, length, output ready);
endinterface

interface dntp_out_if;
  logic                            valid;
  logic                            ready;
  logic [dntp_pkg::ADDR_W-1:0]     vram_address;
  logic [dntp_pkg::CHAR_W-1:0]     character;
  logic                            last;

  modport source (output valid, vram_address, character, last, input ready);
  modport sink   (input valid, vram_address, character, last, output ready);
endinterface

### rtl/decimal_number_tile_printer.sv
// Decimal number tile printer, top level: config register, digit pipeline, character emitter.
// Depends on dntp_pkg, dntp_ifs, dntp_conv and decimal_number_tile_printer_macros.svh.
//
// Each input transaction carries a screen column, line, 16-bit value and a
// length. The value is turned into five ASCII decimal digits with leading
// zeros (including an all-zero units digit) shown as spaces, and the rightmost
// min(length, 5) characters go out as result transactions, one per cycle while
// the output is ready, each with the video memory address name_table_base +
// line*32 + column + k, modulo 2^14; last marks the final character. A length
// of 0 is accepted and gives no result. The input is ready every cycle while
// the pipeline has room; an item of length n holds the result port for n
// transactions, so the single output port sets the sustained rate. An item
// passes through the five digit stages and the emitter register before its
// first result. name_table_base (reset 6144) sits at byte address 0 of the
// APB port; write it only while the block is idle.
`include "decimal_number_tile_printer_macros.svh"

module decimal_number_tile_printer (
  input  logic                  clk,
  input  logic                  rst_n,
  // config port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  // channels
  dntp_in_if.sink               in_chan,
  dntp_out_if.source            out_chan
);

  // ---------------- config register ----------------
  dntp_pkg::addr_t ntb_r;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ntb_r <= dntp_pkg::NTB_RESET;
    end else if (cfg_wr && (cfg_paddr[2] == dntp_pkg::REG_NTB)) begin
      ntb_r <= cfg_pwdata[dntp_pkg::ADDR_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == dntp_pkg::REG_NTB) ?
                      {{(32-dntp_pkg::ADDR_W){1'b0}}, ntb_r} : 32'd0;

  // ---------------- input side ----------------
  dntp_pkg::conv_in_t  conv_in;
  dntp_pkg::conv_out_t conv_out;
  logic                conv_in_valid;
  logic                conv_in_ready;
  logic                conv_out_valid;
  logic                conv_out_ready;
  dntp_pkg::len_t      len_sat;

  // saturate length at five
  assign len_sat = (in_chan.length > dntp_pkg::LEN_W'(dntp_pkg::DIGITS)) ?
                   dntp_pkg::LEN_W'(dntp_pkg::DIGITS) : in_chan.length;

  // first character address, wraps at 14 bits
  assign conv_in.addr  = ntb_r
                       + dntp_pkg::ADDR_W'(in_chan.line) * dntp_pkg::ADDR_W'(dntp_pkg::ROW_TILES)
                       + dntp_pkg::ADDR_W'(in_chan.column);
  assign conv_in.value = in_chan.value;
  assign conv_in.len   = len_sat;

  // zero-length transactions are taken and dropped here
  assign conv_in_valid = in_chan.valid && (in_chan.length != '0);
  assign in_chan.ready = conv_in_ready;

  dntp_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (conv_in_valid),
    .in_ready  (conv_in_ready),
    .in_data   (conv_in),
    .out_valid (conv_out_valid),
    .out_ready (conv_out_ready),
    .out_data  (conv_out)
  );

  // ---------------- character build ----------------
  dntp_pkg::char_t text [dntp_pkg::DIGITS];
  dntp_pkg::char_t load_chars [dntp_pkg::DIGITS];

  always_comb begin
    logic       seen;
    logic [3:0] idx;
    seen = 1'b0;
    for (int k = 0; k < dntp_pkg::DIGITS; k++) begin
      seen    = seen || (conv_out.digit[k] != '0);
      text[k] = seen ? (dntp_pkg::CHAR_ZERO + dntp_pkg::CHAR_W'(conv_out.digit[k]))
                     : dntp_pkg::CHAR_SPACE;
    end
    // rightmost len characters, left aligned
    for (int k = 0; k < dntp_pkg::DIGITS; k++) begin
      idx = 4'(k) + 4'(dntp_pkg::DIGITS) - 4'(conv_out.len);
      if (idx < 4'(dntp_pkg::DIGITS)) begin
        load_chars[k] = text[idx[2:0]];
      end else begin
        load_chars[k] = dntp_pkg::CHAR_SPACE;
      end
    end
  end

  // ---------------- emitter (output register) ----------------
  logic            out_valid_r;
  dntp_pkg::len_t  remain_r;
  dntp_pkg::addr_t addr_r;
  dntp_pkg::addr_t addr_inc;
  dntp_pkg::char_t chars_r [dntp_pkg::DIGITS];
  logic            xfer;
  logic            done;
  logic            load;
  logic            remain_ok;
  logic            char_ok;

  assign xfer           = out_valid_r && out_chan.ready;
  assign done           = xfer && (remain_r == dntp_pkg::LEN_W'(1));
  assign conv_out_ready = !out_valid_r || done;
  assign load           = conv_out_valid && conv_out_ready;
  assign addr_inc       = addr_r + dntp_pkg::ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      remain_r    <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      remain_r    <= conv_out.len;
    end else if (xfer) begin
      out_valid_r <= !done;
      remain_r    <= remain_r - dntp_pkg::LEN_W'(1);
    end
  end

  // payload: load a fresh string or shift one character out per transaction
  always_ff @(posedge clk) begin
    if (load) begin
      addr_r <= conv_out.addr;
      for (int k = 0; k < dntp_pkg::DIGITS; k++) begin
        chars_r[k] <= load_chars[k];
      end
    end else if (xfer) begin
      addr_r <= addr_inc;
      for (int k = 0; k < dntp_pkg::DIGITS - 1; k++) begin
        chars_r[k] <= chars_r[k+1];
      end
      chars_r[dntp_pkg::DIGITS-1] <= dntp_pkg::CHAR_SPACE;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.vram_address = addr_r;
  assign out_chan.character    = chars_r[0];
  assign out_chan.last         = (remain_r == dntp_pkg::LEN_W'(1));

  assign remain_ok = remain_r != '0 && remain_r <= dntp_pkg::LEN_W'(dntp_pkg::DIGITS);
  assign char_ok   = (chars_r[0] == dntp_pkg::CHAR_SPACE)
                  || (chars_r[0] >= dntp_pkg::CHAR_ZERO && chars_r[0] <= dntp_pkg::CHAR_NINE);

  `DNTP_ASSERT_IMPL(a_remain_range, out_valid_r, remain_ok, "character count out of range")
  `DNTP_ASSERT_NEXT(a_more_follow, xfer && !done, out_valid_r, "string ended before last")
  `DNTP_ASSERT_NEXT(a_addr_step, xfer && !done, addr_r == $past(addr_inc), "address skipped")
  `DNTP_ASSERT_IMPL(a_char_code, out_valid_r, char_ok, "character not digit or space")

endmodule

### rtl/dntp_conv.sv
// Five-stage binary to decimal digit pipeline with valid/ready stall control.
// Depends on dntp_pkg and decimal_number_tile_printer_macros.svh.
`include "decimal_number_tile_printer_macros.svh"

module dntp_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dntp_pkg::conv_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dntp_pkg::conv_out_t out_data
);

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic ld1, ld2, ld3, ld4, ld5;

  // stage 1: captured item
  logic [dntp_pkg::VALUE_W-1:0] s1_value_r;
  dntp_pkg::addr_t              s1_addr_r;
  dntp_pkg::len_t               s1_len_r;
  // stage 2: value / 100
  logic [dntp_pkg::VALUE_W-1:0] s2_value_r;
  logic [9:0]                   s2_q1_r;
  dntp_pkg::addr_t              s2_addr_r;
  dntp_pkg::len_t               s2_len_r;
  // stage 3: low pair, top digit
  logic [9:0]                   s3_q1_r;
  logic [6:0]                   s3_r1_r;
  logic [2:0]                   s3_q2_r;
  dntp_pkg::addr_t              s3_addr_r;
  dntp_pkg::len_t               s3_len_r;
  // stage 4: middle pair
  logic [2:0]                   s4_q2_r;
  logic [6:0]                   s4_r1_r;
  logic [6:0]                   s4_r2_r;
  dntp_pkg::addr_t              s4_addr_r;
  dntp_pkg::len_t               s4_len_r;
  // stage 5: tens of each pair
  logic [2:0]                   s5_q2_r;
  logic [6:0]                   s5_r1_r;
  logic [6:0]                   s5_r2_r;
  logic [3:0]                   s5_t1_r;
  logic [3:0]                   s5_t2_r;
  dntp_pkg::addr_t              s5_addr_r;
  dntp_pkg::len_t               s5_len_r;

  logic [33:0] q1_prod;
  logic [15:0] q1x100;
  logic [15:0] q2_prod;
  logic [9:0]  q2x100;
  logic [13:0] t1_prod;
  logic [13:0] t2_prod;
  logic [6:0]  u1_full;
  logic [6:0]  u2_full;

  // range checks for the assertions
  logic pair_ok;
  logic tens_ok;

  // a stage loads when it is empty or its content moves on
  assign ld5      = v4_r && (!v5_r || out_ready);
  assign ld4      = v3_r && (!v4_r || ld5);
  assign ld3      = v2_r && (!v3_r || ld4);
  assign ld2      = v1_r && (!v2_r || ld3);
  assign in_ready = !v1_r || ld2;
  assign ld1      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= ld1 || (v1_r && !ld2);
      v2_r <= ld2 || (v2_r && !ld3);
      v3_r <= ld3 || (v3_r && !ld4);
      v4_r <= ld4 || (v4_r && !ld5);
      v5_r <= ld5 || (v5_r && !out_ready);
    end
  end

  assign q1_prod = 34'(s1_value_r) * 34'(dntp_pkg::MUL_DIV100_WIDE);
  assign q1x100  = 16'(s2_q1_r) * 16'd100;
  assign q2_prod = 16'(s2_q1_r) * 16'(dntp_pkg::MUL_DIV100_NARROW);
  assign q2x100  = 10'(s3_q2_r) * 10'd100;
  assign t1_prod = 14'(s4_r1_r) * 14'(dntp_pkg::MUL_DIV10);
  assign t2_prod = 14'(s4_r2_r) * 14'(dntp_pkg::MUL_DIV10);

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_value_r <= in_data.value;
      s1_addr_r  <= in_data.addr;
      s1_len_r   <= in_data.len;
    end
    if (ld2) begin
      s2_value_r <= s1_value_r;
      s2_q1_r    <= q1_prod[33:24];
      s2_addr_r  <= s1_addr_r;
      s2_len_r   <= s1_len_r;
    end
    if (ld3) begin
      s3_q1_r   <= s2_q1_r;
      s3_r1_r   <= 7'(s2_value_r - q1x100);
      s3_q2_r   <= q2_prod[14:12];
      s3_addr_r <= s2_addr_r;
      s3_len_r  <= s2_len_r;
    end
    if (ld4) begin
      s4_q2_r   <= s3_q2_r;
      s4_r1_r   <= s3_r1_r;
      s4_r2_r   <= 7'(s3_q1_r - q2x100);
      s4_addr_r <= s3_addr_r;
      s4_len_r  <= s3_len_r;
    end
    if (ld5) begin
      s5_q2_r   <= s4_q2_r;
      s5_r1_r   <= s4_r1_r;
      s5_r2_r   <= s4_r2_r;
      s5_t1_r   <= t1_prod[13:10];
      s5_t2_r   <= t2_prod[13:10];
      s5_addr_r <= s4_addr_r;
      s5_len_r  <= s4_len_r;
    end
  end

  assign u1_full = s5_r1_r - 7'(s5_t1_r) * 7'd10;
  assign u2_full = s5_r2_r - 7'(s5_t2_r) * 7'd10;

  assign out_valid         = v5_r;
  assign out_data.digit[0] = 4'(s5_q2_r);
  assign out_data.digit[1] = s5_t2_r;
  assign out_data.digit[2] = u2_full[3:0];
  assign out_data.digit[3] = s5_t1_r;
  assign out_data.digit[4] = u1_full[3:0];
  assign out_data.addr     = s5_addr_r;
  assign out_data.len      = s5_len_r;

  assign pair_ok = s4_r1_r < 7'd100 && s4_r2_r < 7'd100 && s4_q2_r <= 3'd6;
  assign tens_ok = s5_t1_r <= 4'd9 && s5_t2_r <= 4'd9 && u1_full <= 7'd9 && u2_full <= 7'd9;

  `DNTP_ASSERT_IMPL(a_q1_range, v2_r, s2_q1_r <= 10'd655, "value/100 out of range")
  `DNTP_ASSERT_IMPL(a_pair_range, v4_r, pair_ok, "digit pair out of range")
  `DNTP_ASSERT_IMPL(a_tens_range, v5_r, tens_ok, "decimal digit out of range")

endmodule
